// ===== src/ppd_pkg.sv =====
// Shared types and constants of the polygon point densifier.
`default_nettype none

package ppd_pkg;

    // Coordinate width and the derived widths of the divide datapath.
    localparam int COORD_BITS = 16;
    localparam int STEP_BITS  = $clog2(COORD_BITS);
    localparam int CNT_BITS   = 5;
    localparam int DIV_BITS   = CNT_BITS + 1;

    localparam int unsigned MAX_BETWEEN = 31;
    localparam logic [CNT_BITS-1:0] POINTS_BETWEEN_RESET = CNT_BITS'(3);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_EMIT
    } state_t;

    // Status and results of the shared two-lane divider.
    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [COORD_BITS-1:0] quot_x;
        logic [CNT_BITS-1:0]   rem_x;
        logic [COORD_BITS-1:0] quot_y;
        logic [CNT_BITS-1:0]   rem_y;
    } div_res_t;

endpackage

`default_nettype wire

// ===== src/ppd_divider.sv =====
// Restoring divider, one quotient bit per cycle for the x and y lanes together.
`default_nettype none

module ppd_divider (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           start,
    input  wire logic [ppd_pkg::DIV_BITS-1:0]   divisor,
    input  wire logic [ppd_pkg::COORD_BITS-1:0] dividend_x,
    input  wire logic [ppd_pkg::COORD_BITS-1:0] dividend_y,
    output ppd_pkg::div_res_t                   res
);

    typedef struct packed {
        logic [ppd_pkg::COORD_BITS-1:0] quot;
        logic [ppd_pkg::CNT_BITS-1:0]   rem;
    } lane_t;

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [ppd_pkg::STEP_BITS-1:0]  cnt_reg, cnt_next;
    logic [ppd_pkg::DIV_BITS-1:0]   divisor_reg, divisor_next;
    lane_t                          lane_x_reg, lane_x_next;
    lane_t                          lane_y_reg, lane_y_next;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    function automatic lane_t div_step(input lane_t cur, input logic [ppd_pkg::DIV_BITS-1:0] d);
        logic [ppd_pkg::DIV_BITS-1:0] trial;
        lane_t                        nxt;
        trial = {cur.rem, cur.quot[ppd_pkg::COORD_BITS-1]};
        nxt.quot = {cur.quot[ppd_pkg::COORD_BITS-2:0], 1'b0};
        if (trial >= d) begin
            nxt.rem     = ppd_pkg::CNT_BITS'(trial - d);
            nxt.quot[0] = 1'b1;
        end else begin
            nxt.rem = ppd_pkg::CNT_BITS'(trial);
        end
        return nxt;
    endfunction

    always_comb begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        divisor_next = divisor_reg;
        lane_x_next  = lane_x_reg;
        lane_y_next  = lane_y_reg;
        if (start) begin
            busy_next    = 1'b1;
            cnt_next     = '0;
            divisor_next = divisor;
            lane_x_next  = '{quot: dividend_x, rem: '0};
            lane_y_next  = '{quot: dividend_y, rem: '0};
        end else if (busy_reg) begin
            lane_x_next = div_step(lane_x_reg, divisor_reg);
            lane_y_next = div_step(lane_y_reg, divisor_reg);
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == ppd_pkg::STEP_BITS'(ppd_pkg::COORD_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        divisor_reg <= divisor_next;
        lane_x_reg  <= lane_x_next;
        lane_y_reg  <= lane_y_next;
    end

    assign res.busy   = busy_reg;
    assign res.done   = done_reg;
    assign res.quot_x = lane_x_reg.quot;
    assign res.rem_x  = lane_x_reg.rem;
    assign res.quot_y = lane_y_reg.quot;
    assign res.rem_y  = lane_y_reg.rem;

endmodule

`default_nettype wire

// ===== src/polygon_point_densifier_unit.sv =====
// Top level of the polygon point densifier: sequencer, stepping datapath, output word.
`default_nettype none

// The block takes the vertices of a closed polygon one word at a time and
// emits a densified outline. Every vertex after the first emits the previous
// vertex (inserted = 0) and then points_between interpolated points toward
// the new vertex (inserted = 1); a vertex flagged closing_vertex also emits
// itself and the points of the closing segment back to the first vertex, and
// the very last word of the polygon carries end_of_polygon. Interpolant k on
// a segment S->E is S + (k*(E-S))/(n+1), truncated toward zero, exact per
// axis. Each segment runs a setup state, the shared restoring divider
// (one quotient bit per cycle, both axes at once) and a wait for its done
// flag, then n+1 output words at one word per cycle while m_ready is high;
// a closing vertex after the first runs two segments, and an opening vertex
// is only recorded and emits nothing.
// The divider produces |E-S| div (n+1) and its remainder once per segment;
// each interpolant then follows by adding that quotient and remainder to a
// running quotient/remainder pair with one compare-and-subtract. s_ready is
// high only while the sequencer is idle, but the last word of a vertex may
// still sit in the output register while the next vertex is taken. The
// points_between register (reset 3) is written with cfg_we/cfg_wdata and
// should only change while the block is idle.
module polygon_point_densifier_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [ppd_pkg::CNT_BITS-1:0]   cfg_wdata,
    input  wire logic                           s_valid,
    output wire logic                           s_ready,
    input  wire logic [ppd_pkg::COORD_BITS-1:0] s_vertex_x,
    input  wire logic [ppd_pkg::COORD_BITS-1:0] s_vertex_y,
    input  wire logic                           s_closing_vertex,
    output wire logic                           m_valid,
    input  wire logic                           m_ready,
    output wire logic [ppd_pkg::COORD_BITS-1:0] m_point_x,
    output wire logic [ppd_pkg::COORD_BITS-1:0] m_point_y,
    output wire logic                           m_inserted,
    output wire logic                           m_end_of_polygon
);

    typedef struct packed {
        logic [ppd_pkg::COORD_BITS-1:0] q;
        logic [ppd_pkg::CNT_BITS-1:0]   r;
    } acc_t;

    ppd_pkg::state_t                state_reg, state_next;

    logic [ppd_pkg::CNT_BITS-1:0]   points_between_reg;
    logic                           have_first_reg;
    logic [ppd_pkg::COORD_BITS-1:0] first_x_reg, first_y_reg;
    logic [ppd_pkg::COORD_BITS-1:0] prev_x_reg, prev_y_reg;

    // Current segment: start, end, direction per axis.
    logic [ppd_pkg::COORD_BITS-1:0] seg_sx_reg, seg_sy_reg, seg_ex_reg, seg_ey_reg;
    logic                           neg_x_reg, neg_y_reg;
    logic                           closing_seg_reg;
    logic                           pending_close_reg;

    logic [ppd_pkg::CNT_BITS-1:0]   k_reg;
    acc_t                           acc_x_reg, acc_y_reg;

    logic                           m_valid_reg;
    logic [ppd_pkg::COORD_BITS-1:0] m_point_x_reg, m_point_y_reg;
    logic                           m_inserted_reg, m_end_reg;

    logic                           in_accept;
    logic                           out_free;
    logic                           div_start;
    logic                           emit_fire;
    logic                           seg_last;

    logic [ppd_pkg::DIV_BITS-1:0]   divisor;
    logic                           load_neg_x, load_neg_y;
    logic [ppd_pkg::COORD_BITS-1:0] load_mag_x, load_mag_y;
    acc_t                           acc_x_new, acc_y_new;
    logic [ppd_pkg::COORD_BITS-1:0] pt_x, pt_y;

    ppd_pkg::div_res_t              div_res;

    // Advance a running quotient/remainder pair by one multiple of the delta.
    function automatic acc_t acc_step(input acc_t cur,
                                      input logic [ppd_pkg::COORD_BITS-1:0] qd,
                                      input logic [ppd_pkg::CNT_BITS-1:0] rd,
                                      input logic [ppd_pkg::DIV_BITS-1:0] d);
        logic [ppd_pkg::DIV_BITS-1:0] rsum;
        acc_t                         nxt;
        rsum = {1'b0, cur.r} + {1'b0, rd};
        if (rsum >= d) begin
            nxt.r = ppd_pkg::CNT_BITS'(rsum - d);
            nxt.q = cur.q + qd + 1'b1;
        end else begin
            nxt.r = ppd_pkg::CNT_BITS'(rsum);
            nxt.q = cur.q + qd;
        end
        return nxt;
    endfunction

    assign in_accept = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign divisor   = {1'b0, points_between_reg} + 1'b1;

    // Segment direction and length, taken in the setup cycle.
    assign load_neg_x = seg_ex_reg < seg_sx_reg;
    assign load_neg_y = seg_ey_reg < seg_sy_reg;
    assign load_mag_x = load_neg_x ? seg_sx_reg - seg_ex_reg : seg_ex_reg - seg_sx_reg;
    assign load_mag_y = load_neg_y ? seg_sy_reg - seg_ey_reg : seg_ey_reg - seg_sy_reg;

    assign acc_x_new = acc_step(acc_x_reg, div_res.quot_x, div_res.rem_x, divisor);
    assign acc_y_new = acc_step(acc_y_reg, div_res.quot_y, div_res.rem_y, divisor);
    assign pt_x = neg_x_reg ? seg_sx_reg - acc_x_new.q : seg_sx_reg + acc_x_new.q;
    assign pt_y = neg_y_reg ? seg_sy_reg - acc_y_new.q : seg_sy_reg + acc_y_new.q;

    ppd_divider u_divider (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (div_start),
        .divisor    (divisor),
        .dividend_x (load_mag_x),
        .dividend_y (load_mag_y),
        .res        (div_res)
    );

    // Sequencer: next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ppd_pkg::ST_IDLE: begin
                if (in_accept && (have_first_reg || s_closing_vertex)) begin
                    state_next = ppd_pkg::ST_LOAD;
                end
            end
            ppd_pkg::ST_LOAD: begin
                state_next = ppd_pkg::ST_DIV;
            end
            ppd_pkg::ST_DIV: begin
                if (div_res.done) begin
                    state_next = ppd_pkg::ST_EMIT;
                end
            end
            ppd_pkg::ST_EMIT: begin
                if (seg_last) begin
                    state_next = pending_close_reg ? ppd_pkg::ST_LOAD : ppd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ppd_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer: control outputs.
    always_comb begin
        div_start = 1'b0;
        emit_fire = 1'b0;
        unique case (state_reg)
            ppd_pkg::ST_LOAD: div_start = 1'b1;
            ppd_pkg::ST_EMIT: emit_fire = out_free;
            default: begin
                div_start = 1'b0;
                emit_fire = 1'b0;
            end
        endcase
        seg_last = emit_fire && (k_reg == points_between_reg);
    end

    assign s_ready = (state_reg == ppd_pkg::ST_IDLE);

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ppd_pkg::ST_IDLE;
            points_between_reg <= ppd_pkg::POINTS_BETWEEN_RESET;
            have_first_reg     <= 1'b0;
            pending_close_reg  <= 1'b0;
            closing_seg_reg    <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                points_between_reg <= cfg_wdata;
            end
            if (in_accept) begin
                // A closing vertex ends the polygon; an opening one starts it.
                have_first_reg <= !s_closing_vertex;
                if (have_first_reg) begin
                    pending_close_reg <= s_closing_vertex;
                    closing_seg_reg   <= 1'b0;
                end else begin
                    pending_close_reg <= 1'b0;
                    closing_seg_reg   <= 1'b1;
                end
            end else if (seg_last && pending_close_reg) begin
                pending_close_reg <= 1'b0;
                closing_seg_reg   <= 1'b1;
            end
            if (emit_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Vertex store, segment registers, stepping accumulators and output word.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            prev_x_reg <= s_vertex_x;
            prev_y_reg <= s_vertex_y;
            if (!have_first_reg) begin
                first_x_reg <= s_vertex_x;
                first_y_reg <= s_vertex_y;
                seg_sx_reg  <= s_vertex_x;
                seg_sy_reg  <= s_vertex_y;
            end else begin
                seg_sx_reg <= prev_x_reg;
                seg_sy_reg <= prev_y_reg;
            end
            seg_ex_reg <= s_vertex_x;
            seg_ey_reg <= s_vertex_y;
        end else if (seg_last && pending_close_reg) begin
            // Chain the closing segment: new vertex back to the first one.
            seg_sx_reg <= seg_ex_reg;
            seg_sy_reg <= seg_ey_reg;
            seg_ex_reg <= first_x_reg;
            seg_ey_reg <= first_y_reg;
        end

        if (div_start) begin
            neg_x_reg <= load_neg_x;
            neg_y_reg <= load_neg_y;
            k_reg     <= '0;
            acc_x_reg <= '0;
            acc_y_reg <= '0;
        end else if (emit_fire) begin
            k_reg <= k_reg + 1'b1;
            if (k_reg != '0) begin
                acc_x_reg <= acc_x_new;
                acc_y_reg <= acc_y_new;
            end
        end

        if (emit_fire) begin
            // The segment opens with its start vertex, then the interpolants.
            if (k_reg == '0) begin
                m_point_x_reg  <= seg_sx_reg;
                m_point_y_reg  <= seg_sy_reg;
                m_inserted_reg <= 1'b0;
            end else begin
                m_point_x_reg  <= pt_x;
                m_point_y_reg  <= pt_y;
                m_inserted_reg <= 1'b1;
            end
            m_end_reg <= closing_seg_reg && (k_reg == points_between_reg);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_point_x        = m_point_x_reg;
    assign m_point_y        = m_point_y_reg;
    assign m_inserted       = m_inserted_reg;
    assign m_end_of_polygon = m_end_reg;

    // The divider reports completion only while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_res.done |-> (state_reg == ppd_pkg::ST_DIV))
        else $error("divider completed outside the divide wait");

    // No division may still be running once the block takes a new vertex.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !div_res.busy)
        else $error("divider busy while accepting a vertex");

    // An opening vertex only records itself and leaves the block idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && !have_first_reg && !s_closing_vertex)
            |=> (state_reg == ppd_pkg::ST_IDLE) && !$rose(m_valid))
        else $error("opening vertex produced output or left the idle state");

endmodule

`default_nettype wire

// ===== dv/ppd_outline_checker.sv =====
`timescale 1ns / 1ps
// Checker for the polygon point densifier: predicts every output word and compares it.
module ppd_outline_checker (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [ppd_pkg::CNT_BITS-1:0]   cfg_wdata,
    input  wire logic                           s_valid,
    input  wire logic                           s_ready,
    input  wire logic [ppd_pkg::COORD_BITS-1:0] s_vertex_x,
    input  wire logic [ppd_pkg::COORD_BITS-1:0] s_vertex_y,
    input  wire logic                           s_closing_vertex,
    input  wire logic                           m_valid,
    input  wire logic                           m_ready,
    input  wire logic [ppd_pkg::COORD_BITS-1:0] m_point_x,
    input  wire logic [ppd_pkg::COORD_BITS-1:0] m_point_y,
    input  wire logic                           m_inserted,
    input  wire logic                           m_end_of_polygon,
    output int                                  error_count,
    output int                                  points_pending
);

    localparam int COORD_W = ppd_pkg::COORD_BITS;
    localparam int CNT_W   = ppd_pkg::CNT_BITS;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               inserted;
        logic               closes;
    } outline_point_t;

    outline_point_t     expected_points[$];
    logic [CNT_W-1:0]   n_between;
    logic               polygon_open;
    logic [COORD_W-1:0] first_x, first_y, last_x, last_y;
    int                 mismatches = 0;

    initial begin
        error_count    = 0;
        points_pending = 0;
    end

    // k-th of n evenly spaced points from s towards e, quotient truncated towards zero
    function automatic logic [COORD_W-1:0] lerp_coord(input logic [COORD_W-1:0] s,
                                                      input logic [COORD_W-1:0] e,
                                                      input int k, input int n);
        longint delta;
        longint step;
        delta = longint'(e) - longint'(s);
        step  = (longint'(k) * delta) / longint'(n + 1);
        return COORD_W'(longint'(s) + step);
    endfunction

    task automatic push_segment(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                                input logic [COORD_W-1:0] ex, input logic [COORD_W-1:0] ey,
                                input int n, input logic closes);
        outline_point_t p;
        for (int k = 0; k <= n; k++) begin
            p.x        = (k == 0) ? sx : lerp_coord(sx, ex, k, n);
            p.y        = (k == 0) ? sy : lerp_coord(sy, ey, k, n);
            p.inserted = (k != 0);
            p.closes   = closes && (k == n);
            expected_points.insert(expected_points.size(), p);
        end
    endtask

    task automatic densify_vertex(input logic [COORD_W-1:0] vx, input logic [COORD_W-1:0] vy,
                                  input logic closing);
        int n;
        n = (int'(n_between) > int'(ppd_pkg::MAX_BETWEEN)) ? int'(ppd_pkg::MAX_BETWEEN)
                                                            : int'(n_between);
        if (!polygon_open) begin
            first_x      = vx;
            first_y      = vy;
            polygon_open = 1'b1;
        end else begin
            push_segment(last_x, last_y, vx, vy, n, 1'b0);
        end
        last_x = vx;
        last_y = vy;
        if (closing) begin
            push_segment(vx, vy, first_x, first_y, n, 1'b1);
            polygon_open = 1'b0;
        end
    endtask

    task automatic check_point();
        outline_point_t want;
        if (expected_points.size() == 0) begin
            $error("unexpected output word: point_x %0d, point_y %0d", m_point_x, m_point_y);
            mismatches++;
        end else begin
            want = expected_points.pop_front();
            if (m_point_x !== want.x) begin
                $error("point_x: expected %0d, actual %0d", want.x, m_point_x);
                mismatches++;
            end
            if (m_point_y !== want.y) begin
                $error("point_y: expected %0d, actual %0d", want.y, m_point_y);
                mismatches++;
            end
            if (m_inserted !== want.inserted) begin
                $error("inserted: expected %0d, actual %0d", want.inserted, m_inserted);
                mismatches++;
            end
            if (m_end_of_polygon !== want.closes) begin
                $error("end_of_polygon: expected %0d, actual %0d", want.closes,
                       m_end_of_polygon);
                mismatches++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            n_between    = ppd_pkg::POINTS_BETWEEN_RESET;
            polygon_open = 1'b0;
            first_x      = '0;
            first_y      = '0;
            last_x       = '0;
            last_y       = '0;
            expected_points.delete();
        end else begin
            if (cfg_we)
                n_between = cfg_wdata;
            if (s_valid && s_ready)
                densify_vertex(s_vertex_x, s_vertex_y, s_closing_vertex);
            if (m_valid && m_ready)
                check_point();
        end
        error_count    <= mismatches;
        points_pending <= expected_points.size();
    end

endmodule

// ===== dv/tb_polygon_point_densifier_unit.sv =====
`timescale 1ns / 1ps
// Testbench top for the polygon point densifier: stimulus, configuration, idling and verdict.
module tb_polygon_point_densifier_unit;

    localparam int COORD_W         = ppd_pkg::COORD_BITS;
    localparam int CNT_W           = ppd_pkg::CNT_BITS;
    localparam int TARGET_VERTICES = 270;
    localparam int PHASE_VERTICES  = 30;
    // The worst silent stretch is the long receiver hold-off; allow it several times over.
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int STALL_LIMIT     = 3000;
    localparam int SETTLE_CYCLES   = 120;

    logic               aclk             = 1'b0;
    logic               aresetn          = 1'b0;
    logic               cfg_we           = 1'b0;
    logic [CNT_W-1:0]   cfg_wdata        = '0;
    logic               s_valid          = 1'b0;
    logic [COORD_W-1:0] s_vertex_x       = '0;
    logic [COORD_W-1:0] s_vertex_y       = '0;
    logic               s_closing_vertex = 1'b0;
    logic               m_ready          = 1'b0;

    wire logic               s_ready;
    wire logic               m_valid;
    wire logic [COORD_W-1:0] m_point_x;
    wire logic [COORD_W-1:0] m_point_y;
    wire logic               m_inserted;
    wire logic               m_end_of_polygon;

    int   error_count;
    int   points_pending;
    int   vertices_sent  = 0;
    int   silent_cycles  = 0;
    int   hold_requests  = 0;
    logic steady         = 1'b0;

    always #5 aclk = ~aclk;

    polygon_point_densifier_unit DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_vertex_x       (s_vertex_x),
        .s_vertex_y       (s_vertex_y),
        .s_closing_vertex (s_closing_vertex),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_point_x        (m_point_x),
        .m_point_y        (m_point_y),
        .m_inserted       (m_inserted),
        .m_end_of_polygon (m_end_of_polygon)
    );

    ppd_outline_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_vertex_x       (s_vertex_x),
        .s_vertex_y       (s_vertex_y),
        .s_closing_vertex (s_closing_vertex),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_point_x        (m_point_x),
        .m_point_y        (m_point_y),
        .m_inserted       (m_inserted),
        .m_end_of_polygon (m_end_of_polygon),
        .error_count      (error_count),
        .points_pending   (points_pending)
    );

    // Result side: drop ready at random, hold it off for a long stretch whenever the
    // stimulus raises a new request, and keep it high throughout the steady stretch.
    initial begin : point_sink
        int holds_served;
        int hold_left;
        holds_served = 0;
        hold_left    = 0;
        forever begin
            @(posedge aclk);
            if (hold_requests != holds_served) begin
                holds_served = hold_requests;
                hold_left    = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (steady) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 14);
            end
        end
    end

    // Watchdog: end the run if no word moves on either channel for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            silent_cycles <= 0;
        else
            silent_cycles <= silent_cycles + 1;
        if (silent_cycles >= STALL_LIMIT) begin
            $display("** polygon_point_densifier_unit: FAILED **");
            $finish;
        end
    end

    // Biased towards the extremes and towards short deltas near them.
    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return COORD_W'($urandom_range(15));
            3:       return ~COORD_W'($urandom_range(15));
            default: return COORD_W'($urandom);
        endcase
    endfunction

    // Offer one vertex word, possibly after a short gap, and hold it until accepted.
    // Returns in the time step of the accepting edge with nothing yet driven there.
    task automatic offer_vertex(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                input logic closing);
        int gap;
        if (!steady && $urandom_range(99) < 14) begin
            gap = $urandom_range(6, 1);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_vertex_x       <= x;
        s_vertex_y       <= y;
        s_closing_vertex <= closing;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        vertices_sent++;
    endtask

    // Stop offering and wait for every predicted point, then let the block settle.
    // The first edge lets the checker's pending count catch up with the last vertex.
    task automatic drain_outline(input int settle);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (points_pending != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic set_points_between(input logic [CNT_W-1:0] value);
        drain_outline(SETTLE_CYCLES);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly ordinary polygons; now and then a lone vertex or a long outline.
    task automatic send_polygon();
        int corners;
        case ($urandom_range(9))
            0:       corners = 1;
            1:       corners = $urandom_range(12, 9);
            default: corners = $urandom_range(6, 2);
        endcase
        for (int i = 0; i < corners; i++)
            offer_vertex(rand_coord(), rand_coord(), i == corners - 1);
    endtask

    initial begin : stimulus
        int phase;
        int phase_start;
        logic [CNT_W-1:0] count;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset count of three: triangle across the full coordinate range.
        offer_vertex('0, '0, 1'b0);
        offer_vertex('1, '1, 1'b0);
        offer_vertex('1, '0, 1'b1);
        // Lone vertex closes on itself.
        offer_vertex(16'h8001, 16'h7FFE, 1'b1);
        // Vertical edge: x stays put on that segment.
        offer_vertex(16'd100, 16'd200, 1'b0);
        offer_vertex(16'd100, 16'd900, 1'b0);
        offer_vertex(16'd1000, 16'd900, 1'b1);
        // Falling deltas that do not divide evenly: truncate towards zero.
        offer_vertex(16'd1000, 16'd1000, 1'b0);
        offer_vertex(16'd7, 16'd3, 1'b1);

        // No inserted points at all.
        set_points_between('0);
        offer_vertex('1, '0, 1'b0);
        offer_vertex('0, '1, 1'b1);
        offer_vertex(16'd5, 16'd5, 1'b1);

        // Largest count.
        set_points_between('1);
        offer_vertex('0, '1, 1'b0);
        offer_vertex('1, '0, 1'b0);
        offer_vertex(16'd1, 16'd1, 1'b1);
        offer_vertex(16'd12345, 16'd54321, 1'b1);

        set_points_between(CNT_W'(1));
        offer_vertex(16'd3, '1, 1'b0);
        offer_vertex('0, '0, 1'b1);

        // Random phases, each under a fresh count; cycle through the extremes.
        phase = 0;
        while (vertices_sent < TARGET_VERTICES) begin
            case (phase % 5)
                0:       count = '0;
                1:       count = '1;
                default: count = CNT_W'($urandom_range(8));
            endcase
            set_points_between(count);
            steady <= (phase % 5 == 4);
            // Long receiver hold-off while the sender keeps offering.
            if (phase % 5 == 2)
                hold_requests <= hold_requests + 1;
            phase_start = vertices_sent;
            while (vertices_sent - phase_start < PHASE_VERTICES) begin
                send_polygon();
                // Pause the sender mid-phase until the outline has fully drained.
                if (phase % 5 == 3 && vertices_sent - phase_start >= PHASE_VERTICES / 2
                    && vertices_sent - phase_start < PHASE_VERTICES / 2 + 8)
                    drain_outline(0);
            end
            phase++;
        end

        steady <= 1'b0;
        drain_outline(SETTLE_CYCLES);
        if (error_count == 0 && points_pending == 0) begin
            $display("** polygon_point_densifier_unit: PASSED **");
        end else begin
            $display("** polygon_point_densifier_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/ppd_pkg.sv
src/ppd_divider.sv
src/polygon_point_densifier_unit.sv
dv/ppd_outline_checker.sv
dv/tb_polygon_point_densifier_unit.sv
